### hdl/nearest_neighbor_image_scaler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor image scaler
// Clocked on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_MACROS_SVH

// same-cycle implication
`define NNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Shared constants and controller/datapath interface types for the scaler.
// ----------------------------------------------------------------------------
package nns_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int MAX_SCALE = 6;
  localparam int FRAC_BITS = 16;

  localparam int DIM_W   = 12;  // size registers, destination counters
  localparam int POS_W   = 11;  // source position, output coordinates
  localparam int STEP_W  = 20;
  localparam int ACC_W   = 32;
  localparam int PIX_W   = 16;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 20;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_STEP_H     = 3'd4;
  localparam logic [CIDX_W-1:0] REG_STEP_V     = 3'd5;

  // register reset values
  localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 12'd320;
  localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 12'd240;
  localparam logic [DIM_W-1:0]  RST_DST_WIDTH  = 12'd320;
  localparam logic [DIM_W-1:0]  RST_DST_HEIGHT = 12'd240;
  localparam logic [STEP_W-1:0] RST_STEP       = 20'd65536;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic row_step;   // claim one more destination row
    logic col_step;   // claim one more destination column
    logic emit_load;  // load the next result into the output register
    logic advance;    // move to the next source position
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic row_start;  // current item opens a source row
    logic row_more;   // another destination row maps here
    logic col_more;   // another destination column maps here
    logic any_out;    // burst is not empty
    logic emit_last;  // next load is the last of the burst
    logic slot_free;  // output register can take a result
  } status_t;

endpackage

### hdl/nns_ctrl.sv
// ----------------------------------------------------------------------------
// nns_ctrl
// Sequencer: row scan, column scan, burst emission, position advance.
// ----------------------------------------------------------------------------
module nns_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  nns_pkg::status_t status,
  output nns_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROWS = 5'b00010,
    S_COLS = 5'b00100,
    S_EMIT = 5'b01000,
    S_ADV  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_ROWS;
        end
      end
      S_ROWS: begin
        if (status.row_start && status.row_more) begin
          cmd.row_step = 1'b1;
        end else begin
          state_next = S_COLS;
        end
      end
      S_COLS: begin
        if (status.col_more) begin
          cmd.col_step = 1'b1;
        end else if (status.any_out) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_ADV;
        end
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            state_next = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/nns_datapath.sv
// ----------------------------------------------------------------------------
// nns_datapath
// Registers, position/accumulator state, mapping compares, output register.
// ----------------------------------------------------------------------------
module nns_datapath #(
  parameter int MAX_SCALE = nns_pkg::MAX_SCALE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [nns_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [nns_pkg::CDATA_W-1:0]  cfg_data,
  input  logic [nns_pkg::PIX_W-1:0]    pixel_value,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nns_pkg::PIX_W-1:0]    out_pixel,
  output logic [nns_pkg::POS_W-1:0]    out_col,
  output logic [nns_pkg::POS_W-1:0]    out_row,
  output logic                         run_last,
  input  nns_pkg::cmd_t                cmd,
  output nns_pkg::status_t             status
);

  localparam int CNT_W = $clog2(MAX_SCALE + 1);
  localparam int DIM_W = nns_pkg::DIM_W;
  localparam int POS_W = nns_pkg::POS_W;
  localparam int ACC_W = nns_pkg::ACC_W;
  localparam int FB    = nns_pkg::FRAC_BITS;
  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(nns_pkg::MAX_DIM);
  localparam logic [CNT_W-1:0] SCALE_MAX = CNT_W'(MAX_SCALE);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  // configuration
  logic [DIM_W-1:0]          source_width, source_height, dest_width, dest_height;
  logic [nns_pkg::STEP_W-1:0] step_horizontal, step_vertical;

  // scan state
  logic [POS_W-1:0] src_col_pos, src_row_pos;
  logic [DIM_W-1:0] next_dest_col, next_dest_row;
  logic [ACC_W-1:0] col_accum, row_accum;
  logic [DIM_W-1:0] row_span_first, col_first;
  logic [CNT_W-1:0] row_span_count, col_count;
  logic [CNT_W-1:0] emit_r, emit_c;
  logic [nns_pkg::PIX_W-1:0] pix;
  logic             row_start;

  logic [DIM_W-1:0] sw, sh, dw, dh;
  logic             row_start_now;
  logic [DIM_W-1:0] col_pos_inc, row_pos_inc;
  logic [DIM_W-1:0] col_sum, row_sum;
  logic [CNT_W-1:0] emit_r_inc, emit_c_inc;
  logic             c_end, r_end;

  always_comb begin
    sw = (source_width == '0) ? DIM_W'(1) : (source_width > DIM_MAX) ? DIM_MAX : source_width;
    sh = (source_height == '0) ? DIM_W'(1) :
         (source_height > DIM_MAX) ? DIM_MAX : source_height;
    dw = (dest_width > DIM_MAX) ? DIM_MAX : dest_width;
    dh = (dest_height > DIM_MAX) ? DIM_MAX : dest_height;
  end

  assign row_start_now = frame_start || (src_col_pos == '0);
  assign col_pos_inc   = {1'b0, src_col_pos} + DIM_W'(1);
  assign row_pos_inc   = {1'b0, src_row_pos} + DIM_W'(1);
  assign emit_r_inc    = emit_r + CNT_ONE;
  assign emit_c_inc    = emit_c + CNT_ONE;
  assign c_end         = (emit_c_inc == col_count);
  assign r_end         = (emit_r_inc == row_span_count);
  assign col_sum       = col_first + {{(DIM_W-CNT_W){1'b0}}, emit_c};
  assign row_sum       = row_span_first + {{(DIM_W-CNT_W){1'b0}}, emit_r};

  always_comb begin
    status.row_start = row_start;
    status.row_more  = (row_span_count < SCALE_MAX) && (next_dest_row < dh) &&
                       (row_accum[ACC_W-1:FB] <= {{(ACC_W-FB-POS_W){1'b0}}, src_row_pos});
    status.col_more  = (col_count < SCALE_MAX) && (next_dest_col < dw) &&
                       (col_accum[ACC_W-1:FB] <= {{(ACC_W-FB-POS_W){1'b0}}, src_col_pos});
    status.any_out   = (row_span_count != '0) && (col_count != '0);
    status.emit_last = c_end && r_end;
    status.slot_free = !out_valid || out_ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= nns_pkg::RST_SRC_WIDTH;
      source_height   <= nns_pkg::RST_SRC_HEIGHT;
      dest_width      <= nns_pkg::RST_DST_WIDTH;
      dest_height     <= nns_pkg::RST_DST_HEIGHT;
      step_horizontal <= nns_pkg::RST_STEP;
      step_vertical   <= nns_pkg::RST_STEP;
    end else if (cfg_valid) begin
      case (cfg_index)
        nns_pkg::REG_SRC_WIDTH:  source_width    <= cfg_data[DIM_W-1:0];
        nns_pkg::REG_SRC_HEIGHT: source_height   <= cfg_data[DIM_W-1:0];
        nns_pkg::REG_DST_WIDTH:  dest_width      <= cfg_data[DIM_W-1:0];
        nns_pkg::REG_DST_HEIGHT: dest_height     <= cfg_data[DIM_W-1:0];
        nns_pkg::REG_STEP_H:     step_horizontal <= cfg_data[nns_pkg::STEP_W-1:0];
        nns_pkg::REG_STEP_V:     step_vertical   <= cfg_data[nns_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      src_col_pos    <= '0;
      src_row_pos    <= '0;
      next_dest_col  <= '0;
      col_accum      <= '0;
      next_dest_row  <= '0;
      row_accum      <= '0;
      row_span_first <= '0;
      row_span_count <= '0;
      col_first      <= '0;
      col_count      <= '0;
      emit_r         <= '0;
      emit_c         <= '0;
      row_start      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        emit_r    <= '0;
        emit_c    <= '0;
        col_count <= '0;
        row_start <= row_start_now;
        if (frame_start) begin
          src_col_pos   <= '0;
          src_row_pos   <= '0;
          next_dest_row <= '0;
          row_accum     <= '0;
        end
        if (row_start_now) begin
          next_dest_col  <= '0;
          col_accum      <= '0;
          col_first      <= '0;
          row_span_first <= frame_start ? '0 : next_dest_row;
          row_span_count <= '0;
        end else begin
          col_first <= next_dest_col;
        end
      end
      if (cmd.row_step) begin
        row_span_count <= row_span_count + CNT_ONE;
        next_dest_row  <= next_dest_row + DIM_W'(1);
        row_accum      <= row_accum + ACC_W'(step_vertical);
      end
      if (cmd.col_step) begin
        col_count     <= col_count + CNT_ONE;
        next_dest_col <= next_dest_col + DIM_W'(1);
        col_accum     <= col_accum + ACC_W'(step_horizontal);
      end
      if (cmd.emit_load) begin
        if (c_end) begin
          emit_c <= '0;
          emit_r <= emit_r_inc;
        end else begin
          emit_c <= emit_c_inc;
        end
      end
      if (cmd.advance) begin
        if (col_pos_inc >= sw) begin
          src_col_pos <= '0;
          if (row_pos_inc >= sh) begin
            src_row_pos   <= '0;
            next_dest_row <= '0;
            row_accum     <= '0;
          end else begin
            src_row_pos <= row_pos_inc[POS_W-1:0];
          end
        end else begin
          src_col_pos <= col_pos_inc[POS_W-1:0];
        end
      end
    end
  end

  // pixel latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix <= pixel_value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_pixel <= pix;
      out_col   <= col_sum[POS_W-1:0];
      out_row   <= row_sum[POS_W-1:0];
      run_last  <= c_end && r_end;
    end
  end

endmodule

### hdl/nearest_neighbor_image_scaler_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_unit
// Nearest-neighbor RGB565 scaler with 4.16 steps, one source pixel in,
// a burst of destination pixels out.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order, frame_start marking the first pixel
// of a frame. Each one yields the destination pixels that map to it, row
// major, with their destination coordinates; run_last flags the last one of
// the burst, and a downscaled pixel may yield none. An item is handled in
// order: accept it, claim destination rows (only at the first pixel of a
// source row), claim destination columns, emit the results, if any, and
// advance. The scan sequencer claims one row or column per cycle and the
// output register takes one result per cycle while the consumer is ready.
// The input is taken only between items; the last result may still sit in
// the output register when the next transaction is accepted. Registers are
// written through the cfg port (always ready); the user must write them
// only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_scaler_unit_macros.svh"

module nearest_neighbor_image_scaler_unit #(
  parameter int MAX_SCALE = nns_pkg::MAX_SCALE  // destination pixels per axis per source
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nns_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [nns_pkg::CDATA_W-1:0]  cfg_data,
  // source pixels
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [nns_pkg::PIX_W-1:0]    pixel_value,
  input  logic                         frame_start,
  // destination pixels
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nns_pkg::PIX_W-1:0]    out_pixel,
  output logic [nns_pkg::POS_W-1:0]    out_col,
  output logic [nns_pkg::POS_W-1:0]    out_row,
  output logic                         run_last
);

  nns_pkg::cmd_t    cmd;
  nns_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer: IDLE -> ROWS -> COLS -> EMIT -> ADV
  nns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // position/accumulator state, mapping compares, output register
  nns_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel   (out_pixel),
    .out_col     (out_col),
    .out_row     (out_row),
    .run_last    (run_last),
    .cmd         (cmd),
    .status      (status)
  );

  // an accepted item closes the input in the following cycle
  `NNS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open after accept")
  // a burst flows without gaps once the consumer takes a result
  `NNS_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !run_last, out_valid, "burst gap")
  // the input stays closed until the burst has reached its last pixel
  `NNS_ASSERT_NOW(a_no_accept_mid_burst, out_valid && !run_last, !in_ready, "input open mid burst")

endmodule
